FILE: hw/rtl/cace_pkg.sv
// Package for the composite artifact color expander.
// Holds the transaction structs, the 16-entry palette and the channel blend.
// No dependencies; every file of the block imports it.
package cace_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned RgbW   = 3 * ChanW;
	localparam int unsigned IndexW = 4;
	localparam int unsigned Lanes  = 4;

	typedef logic [IndexW-1:0] color_idx_t;
	typedef logic [ChanW-1:0]  chan_t;
	typedef logic [RgbW-1:0]   rgb_t;

	typedef struct packed {
		logic [7:0]  video_byte;
		color_idx_t  next_high_nibble;
	} byte_item_t;

	typedef struct packed {
		rgb_t pixel0_rgb;
		rgb_t pixel1_rgb;
		rgb_t pixel2_rgb;
		rgb_t pixel3_rgb;
	} pixel_item_t;

	// One lane's job: the first color and the color it blends toward.
	typedef struct packed {
		color_idx_t first;
		color_idx_t toward;
	} lane_req_t;

	localparam chan_t C00 = 8'h00;
	localparam chan_t C55 = 8'h55;
	localparam chan_t CAA = 8'haa;
	localparam chan_t CFF = 8'hff;

	// Fixed palette, red in 23:16, green in 15:8, blue in 7:0.
	function automatic rgb_t palette(input color_idx_t idx);
		rgb_t c;
		case (idx)
			4'd0:    c = {C00, C00, C00};
			4'd1:    c = {C00, C55, C00};
			4'd2:    c = {C00, C00, C55};
			4'd3:    c = {C00, CFF, CFF};
			4'd4:    c = {CAA, C55, C55};
			4'd5:    c = {CAA, CAA, CAA};
			4'd6:    c = {CAA, C00, CAA};
			4'd7:    c = {C55, C55, CFF};
			4'd8:    c = {CAA, C00, C00};
			4'd9:    c = {C00, CAA, C00};
			4'd10:   c = {CAA, CAA, C55};
			4'd11:   c = {CAA, CFF, C55};
			4'd12:   c = {CAA, C00, CAA};
			4'd13:   c = {CFF, CAA, C55};
			4'd14:   c = {CFF, C55, C55};
			4'd15:   c = {CFF, CFF, CFF};
			default: c = {C00, C00, C00};
		endcase
		return c;
	endfunction

	// a + (b - a) / 2 with the signed halving truncated toward zero.
	function automatic chan_t half_blend(input chan_t a, input chan_t b);
		chan_t d;
		chan_t r;
		if (b >= a) begin
			d = b - a;
			r = a + (d >> 1);
		end else begin
			d = a - b;
			r = a - (d >> 1);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/cace_lane.sv
// One blend lane: looks up two palette colors and blends the first toward the second.
// Depends on cace_pkg for the palette, the blend function and lane_req_t.
module cace_lane
	import cace_pkg::*;
(
	input  lane_req_t req,
	output rgb_t      rgb
);

	rgb_t a;
	rgb_t b;

	assign a = palette(req.first);
	assign b = palette(req.toward);

	// Blend each channel on its own.
	assign rgb[23:16] = half_blend(a[23:16], b[23:16]);
	assign rgb[15:8]  = half_blend(a[15:8],  b[15:8]);
	assign rgb[7:0]   = half_blend(a[7:0],   b[7:0]);

endmodule

FILE: hw/rtl/cace_merge.sv
// Merging stage: packs the lane results into one transaction and registers it,
// with a skid entry that takes one more transaction while the output stalls.
// Depends on cace_pkg.
module cace_merge
	import cace_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_take,
	input  rgb_t        lane_rgb [Lanes],
	output logic        skid_full,
	output logic        valid,
	input  logic        stall,
	output pixel_item_t data
);

	pixel_item_t merged;
	pixel_item_t out_q;
	pixel_item_t skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        out_free;

	assign merged = '{pixel0_rgb: lane_rgb[0], pixel1_rgb: lane_rgb[1],
	                  pixel2_rgb: lane_rgb[2], pixel3_rgb: lane_rgb[3]};

	assign out_free = !out_valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_take;
			skid_valid_q <= 1'b0;
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : merged;
		end else if (in_take) begin
			skid_q <= merged;
		end
	end

	assign skid_full = skid_valid_q;
	assign valid     = out_valid_q;
	assign data      = out_q;

endmodule

FILE: hw/rtl/composite_artifact_color_expander.sv
// Top level of the composite artifact color expander.
// Instantiates four cace_lane blend lanes and the cace_merge output stage; uses cace_pkg.
//
// Usage:
//   Input channel (byte_*): one transaction carries a video memory byte and the
//   high nibble of the byte that follows it. Accepted at a rising edge where
//   byte_valid is high and byte_stall is low.
//   Output channel (pixel_*): one transaction carries four 24-bit RGB pixels:
//   high-nibble color, low color blended toward high, low color, and next-high
//   color blended toward low. Delivered where pixel_valid is high and
//   pixel_stall is low.
//   Each accepted byte is registered in the output register, or in the skid entry
//   while the output stalls. Throughput: one byte per cycle while pixel_stall is
//   low, set by the four side-by-side lanes that do the lookups and blends combinationally.
//   Stalls: the output register holds while pixel_stall is high; one more
//   transaction lands in the skid entry, after which byte_stall rises until the
//   output drains. byte_stall comes straight from a register.
//   Reset: arst_n clears both valid flags; no pixel data is pending after it.
//   There is no configuration and no state carried from byte to byte.
module composite_artifact_color_expander
	import cace_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  byte_item_t  byte_data,
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output pixel_item_t pixel_data
);

	color_idx_t hi;
	color_idx_t lo;
	color_idx_t nx;
	lane_req_t  req [Lanes];
	rgb_t       lane_rgb [Lanes];
	logic       skid_full;
	logic       take;

	// Split the byte into its two palette indices.
	assign hi = byte_data.video_byte[7:4];
	assign lo = byte_data.video_byte[3:0];
	assign nx = byte_data.next_high_nibble;

	// Lane jobs: a blend of a color with itself gives the plain color.
	assign req[0] = '{first: hi, toward: hi};
	assign req[1] = '{first: lo, toward: hi};
	assign req[2] = '{first: lo, toward: lo};
	assign req[3] = '{first: nx, toward: lo};

	for (genvar i = 0; i < Lanes; i++) begin : g_lane
		cace_lane u_lane (
			.req (req[i]),
			.rgb (lane_rgb[i])
		);
	end

	// Accept whenever the skid entry has room.
	assign byte_stall = skid_full;
	assign take       = byte_valid && !skid_full;

	cace_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (take),
		.lane_rgb  (lane_rgb),
		.skid_full (skid_full),
		.valid     (pixel_valid),
		.stall     (pixel_stall),
		.data      (pixel_data)
	);

endmodule
